/* rtl/core/asd_pkg.sv */
// Shared types, constants and helpers for the accelerometer shake detector.
package asd_pkg;

  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned COUNT_BITS   = 8;
  localparam int unsigned THR_BITS     = 32;
  localparam int unsigned CFG_CNT_BITS = 8;
  localparam int unsigned CFG_BITS     = 32;
  localparam int unsigned CFG_IDX_BITS = 3;

  // squared magnitude of three samples: 3 * 2^(2S-2) < 2^(2S)
  localparam int unsigned MAG_BITS  = 2 * SAMPLE_BITS;
  localparam int unsigned CMP_BITS  = (MAG_BITS > THR_BITS) ? MAG_BITS : THR_BITS;
  localparam int unsigned DOT_BITS  = MAG_BITS + 2;
  localparam int unsigned CNTC_BITS = (COUNT_BITS > CFG_CNT_BITS) ? COUNT_BITS : CFG_CNT_BITS;

  localparam logic [THR_BITS-1:0]     QUIET_THR_RST  = THR_BITS'(20132659);
  localparam logic [THR_BITS-1:0]     ACTIVE_THR_RST = THR_BITS'(33554432);
  localparam logic [CFG_CNT_BITS-1:0] MIN_QUIET_RST  = CFG_CNT_BITS'(5);
  localparam logic [CFG_CNT_BITS-1:0] MIN_ACTIVE_RST = CFG_CNT_BITS'(5);
  localparam logic [CFG_CNT_BITS-1:0] MIN_REV_RST    = CFG_CNT_BITS'(2);
  localparam logic [CFG_CNT_BITS-1:0] TIMEOUT_RST    = CFG_CNT_BITS'(8);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_QUIET_THR  = 3'd0,
    CFG_ACTIVE_THR = 3'd1,
    CFG_MIN_QUIET  = 3'd2,
    CFG_MIN_ACTIVE = 3'd3,
    CFG_MIN_REV    = 3'd4,
    CFG_TIMEOUT    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } sample_t;

  typedef struct packed {
    logic [THR_BITS-1:0]     quiet_thr;
    logic [THR_BITS-1:0]     active_thr;
    logic [CFG_CNT_BITS-1:0] min_quiet;
    logic [CFG_CNT_BITS-1:0] min_active;
    logic [CFG_CNT_BITS-1:0] min_rev;
    logic [CFG_CNT_BITS-1:0] timeout;
  } cfg_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  // count strictly above a configured limit
  function automatic logic cnt_gt(input logic [COUNT_BITS-1:0]   c,
                                  input logic [CFG_CNT_BITS-1:0] lim);
    return CNTC_BITS'(c) > CNTC_BITS'(lim);
  endfunction

endpackage

/* rtl/core/accelerometer_shake_detector_unit.sv */
// Throughput: one word per cycle while the output is not stalled.
// A word passes the input register, magnitude register and result register in order.
// The gesture state is updated in the single step between the magnitude and
// result registers, so consecutive words never wait on each other.
// Reset clears the pipeline valids, all counts and the last sample, and loads
// the default thresholds and limits.
module accelerometer_shake_detector_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [asd_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [asd_pkg::CFG_BITS-1:0]           cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_x_i,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_y_i,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   shake_detected_o
);
  import asd_pkg::*;

  cfg_t                cfg_q;
  logic                stg_valid;
  logic                stg_ready;
  sample_t             stg_sample;
  logic [MAG_BITS-1:0] stg_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quiet_thr  <= QUIET_THR_RST;
      cfg_q.active_thr <= ACTIVE_THR_RST;
      cfg_q.min_quiet  <= MIN_QUIET_RST;
      cfg_q.min_active <= MIN_ACTIVE_RST;
      cfg_q.min_rev    <= MIN_REV_RST;
      cfg_q.timeout    <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_QUIET_THR:  cfg_q.quiet_thr  <= cfg_data_i[THR_BITS-1:0];
        CFG_ACTIVE_THR: cfg_q.active_thr <= cfg_data_i[THR_BITS-1:0];
        CFG_MIN_QUIET:  cfg_q.min_quiet  <= cfg_data_i[CFG_CNT_BITS-1:0];
        CFG_MIN_ACTIVE: cfg_q.min_active <= cfg_data_i[CFG_CNT_BITS-1:0];
        CFG_MIN_REV:    cfg_q.min_rev    <= cfg_data_i[CFG_CNT_BITS-1:0];
        CFG_TIMEOUT:    cfg_q.timeout    <= cfg_data_i[CFG_CNT_BITS-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  asd_mag u_mag (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .accel_x_i    (accel_x_i),
    .accel_y_i    (accel_y_i),
    .accel_z_i    (accel_z_i),
    .stg_valid_o  (stg_valid),
    .stg_ready_i  (stg_ready),
    .stg_sample_o (stg_sample),
    .stg_mag_o    (stg_mag)
  );

  asd_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .stg_valid_i      (stg_valid),
    .stg_ready_o      (stg_ready),
    .stg_sample_i     (stg_sample),
    .stg_mag_i        (stg_mag),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .shake_detected_o (shake_detected_o)
  );

endmodule

/* rtl/core/asd_mag.sv */
// Input register and squared-magnitude stage of the shake detector.
module asd_mag (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_x_i,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_y_i,
  input  logic signed [asd_pkg::SAMPLE_BITS-1:0] accel_z_i,
  output logic                               stg_valid_o,
  input  logic                               stg_ready_i,
  output asd_pkg::sample_t                   stg_sample_o,
  output logic [asd_pkg::MAG_BITS-1:0]       stg_mag_o
);
  import asd_pkg::*;

  logic                          in_v_q;
  sample_t                       in_s_q;
  logic                          mag_v_q;
  sample_t                       mag_s_q;
  logic [MAG_BITS-1:0]           mag_q;
  logic                          mag_rdy;
  logic                          in_rdy;
  logic signed [MAG_BITS-1:0]    sq_x;
  logic signed [MAG_BITS-1:0]    sq_y;
  logic signed [MAG_BITS-1:0]    sq_z;
  logic [MAG_BITS-1:0]           mag_d;

  assign mag_rdy    = !mag_v_q || stg_ready_i;
  assign in_rdy     = !in_v_q || mag_rdy;
  assign in_stall_o = !in_rdy;

  assign sq_x  = MAG_BITS'(in_s_q.x) * MAG_BITS'(in_s_q.x);
  assign sq_y  = MAG_BITS'(in_s_q.y) * MAG_BITS'(in_s_q.y);
  assign sq_z  = MAG_BITS'(in_s_q.z) * MAG_BITS'(in_s_q.z);
  assign mag_d = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mag_v_q <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_v_q <= in_valid_i;
      end
      if (mag_rdy) begin
        mag_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_valid_i) begin
      in_s_q <= '{x: accel_x_i, y: accel_y_i, z: accel_z_i};
    end
    if (mag_rdy && in_v_q) begin
      mag_s_q <= in_s_q;
      mag_q   <= mag_d;
    end
  end

  assign stg_valid_o  = mag_v_q;
  assign stg_sample_o = mag_s_q;
  assign stg_mag_o    = mag_q;

endmodule

/* rtl/core/asd_ctrl.sv */
// Gesture state, counters and result register of the shake detector.
module asd_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  asd_pkg::cfg_t                cfg_i,
  input  logic                         stg_valid_i,
  output logic                         stg_ready_o,
  input  asd_pkg::sample_t             stg_sample_i,
  input  logic [asd_pkg::MAG_BITS-1:0] stg_mag_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         shake_detected_o
);
  import asd_pkg::*;

  sample_t                     last_q, last_d;
  logic [MAG_BITS-1:0]         last_mag_q, last_mag_d;
  logic [COUNT_BITS-1:0]       act_cnt_q, act_cnt_d;
  logic [COUNT_BITS-1:0]       qui_cnt_q, qui_cnt_d;
  logic [COUNT_BITS-1:0]       rev_cnt_q, rev_cnt_d;
  logic                        out_v_q;
  logic                        shake_q, shake_d;

  logic                        rdy;
  logic                        adv;
  logic                        quiet;
  logic                        active;
  logic                        fire;
  logic                        clear;
  logic signed [MAG_BITS-1:0]  p_x;
  logic signed [MAG_BITS-1:0]  p_y;
  logic signed [MAG_BITS-1:0]  p_z;
  logic signed [DOT_BITS-1:0]  proj;
  logic signed [DOT_BITS-1:0]  last_mag_s;
  logic                        reversal;

  assign rdy         = !out_v_q || !out_stall_i;
  assign adv         = stg_valid_i && rdy;
  assign stg_ready_o = rdy;

  assign quiet  = CMP_BITS'(stg_mag_i) < CMP_BITS'(cfg_i.quiet_thr);
  assign active = !quiet && (CMP_BITS'(stg_mag_i) > CMP_BITS'(cfg_i.active_thr));

  assign fire  = cnt_gt(qui_cnt_q, cfg_i.min_quiet) && cnt_gt(act_cnt_q, cfg_i.min_active) &&
                 cnt_gt(rev_cnt_q, cfg_i.min_rev);
  // a shake restarts the quiet count at one, so only an unfired stretch can time out
  assign clear = fire || cnt_gt(qui_cnt_q, cfg_i.timeout);

  // last . (s - last) < 0  <=>  last . s < |last|^2, the stored magnitude
  assign p_x        = MAG_BITS'(last_q.x) * MAG_BITS'(stg_sample_i.x);
  assign p_y        = MAG_BITS'(last_q.y) * MAG_BITS'(stg_sample_i.y);
  assign p_z        = MAG_BITS'(last_q.z) * MAG_BITS'(stg_sample_i.z);
  assign proj       = DOT_BITS'(p_x) + DOT_BITS'(p_y) + DOT_BITS'(p_z);
  assign last_mag_s = $signed({2'b00, last_mag_q});
  assign reversal   = proj < last_mag_s;

  always_comb begin
    last_d     = last_q;
    last_mag_d = last_mag_q;
    act_cnt_d  = act_cnt_q;
    qui_cnt_d  = qui_cnt_q;
    rev_cnt_d  = rev_cnt_q;
    shake_d    = 1'b0;
    if (quiet) begin
      shake_d   = fire;
      qui_cnt_d = sat_inc(fire ? '0 : qui_cnt_q);
      if (clear) begin
        last_d     = '0;
        last_mag_d = '0;
        act_cnt_d  = '0;
        rev_cnt_d  = '0;
      end
    end else if (active) begin
      if (reversal) begin
        rev_cnt_d = sat_inc(rev_cnt_q);
      end
      last_d     = stg_sample_i;
      last_mag_d = stg_mag_i;
      act_cnt_d  = sat_inc(act_cnt_q);
      qui_cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      last_mag_q <= '0;
      act_cnt_q  <= '0;
      qui_cnt_q  <= '0;
      rev_cnt_q  <= '0;
      out_v_q    <= 1'b0;
    end else begin
      if (adv) begin
        last_q     <= last_d;
        last_mag_q <= last_mag_d;
        act_cnt_q  <= act_cnt_d;
        qui_cnt_q  <= qui_cnt_d;
        rev_cnt_q  <= rev_cnt_d;
      end
      if (rdy) begin
        out_v_q <= stg_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      shake_q <= shake_d;
    end
  end

  assign out_valid_o      = out_v_q;
  assign shake_detected_o = shake_q;

endmodule

/* sim/accelerometer_shake_detector_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the accelerometer shake detector unit.
module accelerometer_shake_detector_unit_test;
  import asd_pkg::*;

  localparam int PIPE_DEPTH   = 2;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;
  localparam int EXPECT_DEPTH = 16;
  localparam logic [THR_BITS-1:0] THR_TOP = 32'hC000_0000;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          cfg_we_i   = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_idx_i  = '0;
  logic [CFG_BITS-1:0]           cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] accel_x_i  = '0;
  logic signed [SAMPLE_BITS-1:0] accel_y_i  = '0;
  logic signed [SAMPLE_BITS-1:0] accel_z_i  = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          shake_detected_o;

  // gesture state mirrored from the block
  cfg_t                  gesture_cfg;
  sample_t               last_active;
  logic [COUNT_BITS-1:0] active_cnt;
  logic [COUNT_BITS-1:0] quiet_cnt;
  logic [COUNT_BITS-1:0] reversal_cnt;
  // expected flags in flight, written at acceptance and read at the output
  logic                  shake_expected [EXPECT_DEPTH];
  int                    expect_wr = 0;
  int                    expect_rd = 0;

  int          burst_left      = 0;
  int          samples_sent    = 0;
  int          shakes_seen     = 0;
  int          settings_loaded = 0;
  int          results_seen    = 0;
  int          mismatch_count  = 0;
  int          cycle_count     = 0;
  stall_mode_e stall_mode      = STALL_NONE;
  int          stall_left      = 0;
  logic        shake_want;

  accelerometer_shake_detector_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .shake_detected_o (shake_detected_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic cfg_t make_settings(input logic [THR_BITS-1:0] quiet_thr,
                                         input logic [THR_BITS-1:0] active_thr,
                                         input logic [CFG_CNT_BITS-1:0] min_quiet,
                                         input logic [CFG_CNT_BITS-1:0] min_active,
                                         input logic [CFG_CNT_BITS-1:0] min_rev,
                                         input logic [CFG_CNT_BITS-1:0] timeout);
    cfg_t s;
    s.quiet_thr  = quiet_thr;
    s.active_thr = active_thr;
    s.min_quiet  = min_quiet;
    s.min_active = min_active;
    s.min_rev    = min_rev;
    s.timeout    = timeout;
    return s;
  endfunction

  function automatic sample_t xyz(input int x, input int y, input int z);
    sample_t s;
    s.x = x[SAMPLE_BITS-1:0];
    s.y = y[SAMPLE_BITS-1:0];
    s.z = z[SAMPLE_BITS-1:0];
    return s;
  endfunction

  // well below any quiet threshold used by the gesture phases
  function automatic sample_t calm_sample();
    return xyz(int'($urandom_range(0, 1000)) - 500, int'($urandom_range(0, 1000)) - 500,
               int'($urandom_range(0, 1000)) - 500);
  endfunction

  // one dominant axis, well above any active threshold used by the gesture phases
  function automatic sample_t strong_sample(input int axis, input bit negative);
    int      peak;
    sample_t s;
    peak = int'($urandom_range(12000, negative ? 32768 : 32767));
    if (negative) peak = -peak;
    s = xyz(int'($urandom_range(0, 6000)) - 3000, int'($urandom_range(0, 6000)) - 3000,
            int'($urandom_range(0, 6000)) - 3000);
    case (axis)
      0:       s.x = SAMPLE_BITS'(peak);
      1:       s.y = SAMPLE_BITS'(peak);
      default: s.z = SAMPLE_BITS'(peak);
    endcase
    return s;
  endfunction

  function automatic sample_t mixed_sample();
    case ($urandom_range(0, 4))
      0:       return strong_sample(int'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
      1:       return calm_sample();
      2:       return xyz($urandom_range(0, 1) ? 32767 : -32768,
                          $urandom_range(0, 1) ? 32767 : -32768,
                          $urandom_range(0, 1) ? 32767 : -32768);
      default: return xyz(int'($urandom), int'($urandom), int'($urandom));
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic void drop_gesture();
    active_cnt   = '0;
    reversal_cnt = '0;
    last_active  = '0;
  endfunction

  // Advance the mirrored state by one sample and return the expected shake flag.
  function automatic logic advance_gesture(input sample_t s);
    longint sx, sy, sz, lx, ly, lz, mag, dot, quiet_lim, active_lim;
    logic   shake;
    sx = s.x;
    sy = s.y;
    sz = s.z;
    lx = last_active.x;
    ly = last_active.y;
    lz = last_active.z;
    quiet_lim  = gesture_cfg.quiet_thr;
    active_lim = gesture_cfg.active_thr;
    mag   = sx * sx + sy * sy + sz * sz;
    shake = 1'b0;
    if (mag < quiet_lim) begin
      if (quiet_cnt > gesture_cfg.min_quiet && active_cnt > gesture_cfg.min_active &&
          reversal_cnt > gesture_cfg.min_rev) begin
        shake = 1'b1;
        drop_gesture();
        quiet_cnt = '0;
      end
      if (quiet_cnt > gesture_cfg.timeout) drop_gesture();
      quiet_cnt = count_up(quiet_cnt);
    end else if (mag > active_lim) begin
      dot = lx * (sx - lx) + ly * (sy - ly) + lz * (sz - lz);
      if (dot < 0) reversal_cnt = count_up(reversal_cnt);
      last_active = s;
      active_cnt  = count_up(active_cnt);
      quiet_cnt   = '0;
    end
    return shake;
  endfunction

  task automatic send_sample(input sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 40));
      gap = int'($urandom_range(0, 5));
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    accel_x_i  <= s.x;
    accel_y_i  <= s.y;
    accel_z_i  <= s.z;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    shake_expected[expect_wr % EXPECT_DEPTH] = advance_gesture(s);
    expect_wr++;
    samples_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expect_wr != expect_rd) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    int                  i;
    cfg_idx_e            idx;
    logic [CFG_BITS-1:0] word;
    wait_for_results();
    for (i = 0; i <= int'(CFG_TIMEOUT); i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_QUIET_THR:  word = s.quiet_thr;
        CFG_ACTIVE_THR: word = s.active_thr;
        CFG_MIN_QUIET:  word = CFG_BITS'(s.min_quiet);
        CFG_MIN_ACTIVE: word = CFG_BITS'(s.min_active);
        CFG_MIN_REV:    word = CFG_BITS'(s.min_rev);
        default:        word = CFG_BITS'(s.timeout);
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= word;
      @(posedge clk_i);
    end
    // an index past the register list must leave everything untouched
    if ($urandom_range(0, 2) == 0) begin
      cfg_idx_i  <= CFG_IDX_BITS'(int'(CFG_TIMEOUT) + 1 + int'($urandom_range(0, 1)));
      cfg_data_i <= $urandom;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    gesture_cfg = s;
    settings_loaded++;
  endtask

  task automatic test_directed_cases();
    int n;
    // power-on settings
    send_sample(xyz(-32768, -32768, -32768));
    send_sample(xyz(32767, 32767, 32767));
    send_sample(xyz(0, 0, 0));
    send_sample(xyz(4096, 4096, 0));  // right on the active threshold: neither band
    for (n = 0; n < 6; n++) send_sample(xyz(n[0] ? -8192 : 8192, 0, 0));
    for (n = 0; n < 7; n++) send_sample(xyz(0, 0, 0));  // last one completes the shake
    send_sample(xyz(16384, -1, 1));
    send_sample(xyz(-16384, 1, -1));
    send_sample(xyz(12, -7, 3));
    // equal thresholds: a sample sitting on them is neither quiet nor active
    load_settings(make_settings(32'h0100_0000, 32'h0100_0000, '0, '0, '0, '0));
    send_sample(xyz(4096, 0, 0));
    send_sample(xyz(4095, 0, 0));
    send_sample(xyz(4097, 0, 0));
    // overlapping thresholds: quiet takes precedence
    load_settings(make_settings(THR_TOP, '0, 8'd255, 8'd255, 8'd255, 8'd255));
    send_sample(xyz(0, 0, 0));
    send_sample(xyz(-32768, -32768, -32768));
    send_sample(xyz(100, -100, 5));
  endtask

  task automatic test_counter_saturation();
    int n;
    // counts must pin at full scale; the shake fires only once quiet pins too
    load_settings(make_settings(QUIET_THR_RST, ACTIVE_THR_RST, 8'd254, 8'd254, 8'd254,
                                8'd255));
    for (n = 0; n < 300; n++) send_sample(strong_sample(0, n[0]));
    for (n = 0; n < 300; n++) send_sample(calm_sample());
  endtask

  task automatic test_gesture_sequences();
    cfg_t s;
    int   phase, target, runs, k, axis;
    bit   negative;
    for (phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        s = make_settings(QUIET_THR_RST, ACTIVE_THR_RST, MIN_QUIET_RST, MIN_ACTIVE_RST,
                          MIN_REV_RST, TIMEOUT_RST);
      end else begin
        s.quiet_thr  = $urandom_range(32'h0010_0000, 32'h0400_0000);
        s.active_thr = s.quiet_thr + $urandom_range(0, 32'h0400_0000);
        s.min_quiet  = CFG_CNT_BITS'($urandom_range(0, 8));
        s.min_active = CFG_CNT_BITS'($urandom_range(0, 8));
        s.min_rev    = CFG_CNT_BITS'($urandom_range(0, 6));
        s.timeout    = CFG_CNT_BITS'(int'(s.min_quiet) + int'($urandom_range(0, 8)));
      end
      load_settings(s);
      target = samples_sent + 100;
      while (samples_sent < target) begin
        axis     = int'($urandom_range(0, 2));
        negative = 1'($urandom_range(0, 1));
        runs     = int'($urandom_range(1, int'(s.min_active) + 6));
        for (k = 0; k < runs; k++) begin
          // mostly swing back and forth, now and then keep pushing the same way
          if ($urandom_range(0, 4) != 0) negative = !negative;
          send_sample(strong_sample(axis, negative));
        end
        runs = int'($urandom_range(1, int'(s.timeout) + 4));
        for (k = 0; k < runs; k++) send_sample(calm_sample());
        if ($urandom_range(0, 5) == 0) send_sample(mixed_sample());
      end
    end
  endtask

  task automatic test_threshold_extremes();
    int n;
    // nothing is quiet, anything nonzero is active
    load_settings(make_settings('0, '0, '0, '0, '0, '0));
    for (n = 0; n < 40; n++) send_sample(n % 8 == 0 ? xyz(0, 0, 0) : mixed_sample());
    // nothing can clear the active threshold, almost everything is quiet
    load_settings(make_settings(THR_TOP, THR_TOP, 8'd255, 8'd255, 8'd255, 8'd255));
    for (n = 0; n < 40; n++) begin
      send_sample(n % 8 == 0 ? xyz(-32768, -32768, -32768) : mixed_sample());
    end
  endtask

  task automatic test_random_noise();
    cfg_t s;
    int   phase, n, span;
    for (phase = 0; phase < 3; phase++) begin
      span = (phase == 0) ? 255 : 4;
      s.quiet_thr  = $urandom_range(0, THR_TOP);
      s.active_thr = $urandom_range(0, THR_TOP);
      s.min_quiet  = CFG_CNT_BITS'($urandom_range(0, span));
      s.min_active = CFG_CNT_BITS'($urandom_range(0, span));
      s.min_rev    = CFG_CNT_BITS'($urandom_range(0, span));
      s.timeout    = CFG_CNT_BITS'($urandom_range(0, span + 4));
      load_settings(s);
      for (n = 0; n < 80; n++) send_sample(mixed_sample());
    end
  endtask

  function automatic void note_mismatch(input string what, input logic want, input logic got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) begin
      $display("mismatch on word %0d (%s): shake_detected expected %b, got %b",
               results_seen, what, want, got);
    end
  endfunction

  // result checker and receive-side stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_seen++;
      if (expect_wr == expect_rd) begin
        note_mismatch("no word expected", 1'bx, shake_detected_o);
      end else begin
        shake_want = shake_expected[expect_rd % EXPECT_DEPTH];
        expect_rd++;
        if (shake_detected_o !== shake_want) note_mismatch("wrong flag", shake_want,
                                                           shake_detected_o);
        else if (shake_want) shakes_seen++;
      end
    end
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = int'($urandom_range(16, 200));
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= stall_left[2];
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL accelerometer_shake_detector_unit");
      $finish;
    end
  end

  initial begin
    gesture_cfg = make_settings(QUIET_THR_RST, ACTIVE_THR_RST, MIN_QUIET_RST, MIN_ACTIVE_RST,
                                MIN_REV_RST, TIMEOUT_RST);
    drop_gesture();
    quiet_cnt = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_counter_saturation();
    test_gesture_sequences();
    test_threshold_extremes();
    test_random_noise();
    wait_for_results();
    $display("Ran %0d samples over %0d register settings; %0d shakes reported.",
             samples_sent, settings_loaded + 1, shakes_seen);
    $display("Covered band edges, overlapping thresholds, count saturation and timeouts.");
    if (mismatch_count == 0 && expect_wr == expect_rd) begin
      $display("PASS accelerometer_shake_detector_unit");
    end else begin
      $display("FAIL accelerometer_shake_detector_unit");
    end
    $finish;
  end

endmodule
